// ===== sv/sdf_pkg.sv =====
package sdf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned HDR_CNT_W = 3;

  localparam logic [HDR_CNT_W-1:0] HEADER_LAST = HDR_CNT_W'(4);

  localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ID_LO = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ID_HI = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HDR_CHK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DATA_CHK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN_ID = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_CHK = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd6;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] HIGHEST_ID = 8'h04;
  localparam logic [LEN_W:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [LEN_W-1:0] MAX_PKT_RESET = 16'd256;

endpackage

// ===== sv/sdf_in_if.sv =====
interface sdf_in_if import sdf_pkg::*; ();
  logic valid;
  logic ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sdf_out_if.sv =====
interface sdf_out_if import sdf_pkg::*; ();
  logic valid;
  logic ready;
  logic is_end;
  logic [BYTE_W-1:0] payload_byte;
  logic [LEN_W-1:0] byte_index;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0] function_id;
  logic [LEN_W-1:0] payload_length;

  modport source (output valid, output is_end, output payload_byte, output byte_index,
                  output status, output function_id, output payload_length,
                  input ready);
  modport sink (input valid, input is_end, input payload_byte, input byte_index,
                input status, input function_id, input payload_length,
                output ready);
endinterface

// ===== sv/serial_packet_deframer.sv =====
// Serial packet deframer: takes one received byte per word on in_ch and frames
// packets of a 5-byte header (sync 0xFE, little-endian length, header checksum),
// a 2-byte function ID, the payload and a data checksum. Each payload byte leaves
// on out_ch as soon as it arrives; every packet or bad header ends with one end
// word carrying status, low ID byte and length. A byte passes an input register
// and a result register; a new byte is taken every cycle, the rate being bounded
// only by the result side taking words. The user must write the packet size limit
// (length + 8) on cfg_we/cfg_wdata while the block is idle; it is not enforced.
module serial_packet_deframer import sdf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  sdf_in_if.sink            in_ch,
  sdf_out_if.source         out_ch
);

  logic [LEN_W-1:0]    max_r;
  logic                in_valid_r;
  logic [BYTE_W-1:0]   in_byte_r;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   hdr_r [3];
  logic [BYTE_W-1:0]   hdr_nxt [3];
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [BYTE_W-1:0]   idl_r, idl_nxt;

  logic                out_valid_r;
  logic                is_end_r, is_end_nxt;
  logic [BYTE_W-1:0]   pbyte_r, pbyte_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [BYTE_W-1:0]   fid_r, fid_nxt;
  logic [LEN_W-1:0]    olen_r, olen_nxt;

  logic                produce;
  logic                consume;
  logic                out_free;
  logic [BYTE_W-1:0]   b;
  logic [LEN_W-1:0]    hdr_len;
  logic [BYTE_W-1:0]   hdr_chk;
  logic [BYTE_W-1:0]   data_sum;
  logic [LEN_W-1:0]    cnt_inc;

  assign b        = in_byte_r;
  assign hdr_len  = {hdr_r[2], hdr_r[1]};
  assign hdr_chk  = ~(hdr_r[1] + hdr_r[2]);
  assign data_sum = sum_r + b;
  assign cnt_inc  = cnt_r + LEN_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    hdr_nxt    = hdr_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    idl_nxt    = idl_r;
    produce    = 1'b0;
    is_end_nxt = 1'b1;
    pbyte_nxt  = '0;
    idx_nxt    = '0;
    st_nxt     = ST_OK;
    fid_nxt    = idl_r;
    olen_nxt   = len_r;
    case (phase_r)
      PH_ID_LO: begin
        idl_nxt   = b;
        sum_nxt   = b;
        phase_nxt = PH_ID_HI;
      end
      PH_ID_HI: begin
        sum_nxt   = data_sum;
        cnt_nxt   = '0;
        phase_nxt = (len_r == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_nxt    = data_sum;
        cnt_nxt    = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CHECK;
        end
        produce    = 1'b1;
        is_end_nxt = 1'b0;
        pbyte_nxt  = b;
        idx_nxt    = cnt_r;
      end
      PH_CHECK: begin
        produce   = 1'b1;
        phase_nxt = PH_HEADER;
        cnt_nxt   = '0;
        if (b == '0) begin
          st_nxt = ST_ZERO_CHK;
        end else if (b != ~sum_r) begin
          st_nxt = ST_DATA_CHK;
        end else if (idl_r > HIGHEST_ID) begin
          st_nxt = ST_UNKNOWN_ID;
        end else begin
          st_nxt = ST_OK;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        case (cnt_r[HDR_CNT_W-1:0])
          3'd1:    hdr_nxt[0] = b;
          3'd2:    hdr_nxt[1] = b;
          3'd3:    hdr_nxt[2] = b;
          default: ;
        endcase
        if (cnt_r[HDR_CNT_W-1:0] != HEADER_LAST) begin
          cnt_nxt = cnt_inc;
        end else begin
          cnt_nxt  = '0;
          len_nxt  = hdr_len;
          fid_nxt  = '0;
          olen_nxt = hdr_len;
          produce  = 1'b1;
          if (hdr_r[0] != SYNC_BYTE) begin
            st_nxt = ST_SYNC;
          end else if (hdr_chk != b) begin
            st_nxt = ST_HDR_CHK;
          end else if ({1'b0, hdr_len} + FRAME_OVERHEAD > {1'b0, max_r}) begin
            st_nxt = ST_TOO_LONG;
          end else begin
            produce   = 1'b0;
            sum_nxt   = '0;
            idl_nxt   = '0;
            phase_nxt = PH_ID_LO;
          end
        end
      end
    endcase
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign consume     = in_valid_r && (!produce || out_free);
  assign in_ch.ready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_PKT_RESET;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HEADER;
      cnt_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      idl_r       <= '0;
      hdr_r       <= '{default: '0};
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (consume) begin
        in_valid_r <= 1'b0;
      end
      if (consume) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        hdr_r   <= hdr_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        idl_r   <= idl_nxt;
      end
      if (consume && produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (consume && produce) begin
      is_end_r <= is_end_nxt;
      pbyte_r  <= pbyte_nxt;
      idx_r    <= idx_nxt;
      st_r     <= st_nxt;
      fid_r    <= fid_nxt;
      olen_r   <= olen_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_end         = is_end_r;
  assign out_ch.payload_byte   = pbyte_r;
  assign out_ch.byte_index     = idx_r;
  assign out_ch.status         = st_r;
  assign out_ch.function_id    = fid_r;
  assign out_ch.payload_length = olen_r;

endmodule
